// File: hdl/frustum_plane_cull_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the frustum plane cull block
// Short forms for implication checks clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_PLANE_CULL_ASSERT_SVH
`define FRUSTUM_PLANE_CULL_ASSERT_SVH

// same-cycle implication
`define FPC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frustum_plane_cull: same-cycle check failed");

// next-cycle implication
`define FPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frustum_plane_cull: next-cycle check failed");

`endif

// File: hdl/fpc_pkg.sv
// ---------------------------------------------------------------------------
// fpc_pkg
// Types, codes and plane tables shared by the frustum plane cull modules.
// ---------------------------------------------------------------------------
package fpc_pkg;

  localparam int IN_TDATA_W  = 264;
  localparam int OUT_TDATA_W = 8;
  localparam int ACCW        = 68;
  localparam int SQRT_STEPS  = 32;
  localparam int MAX_EXTRACT = 6;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_BOX     = 2'd2,
    OP_SPHERE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EX_RD,
    ST_EX_SQ,
    ST_EX_ROOT,
    ST_EX_DIV,
    ST_EX_ZERO,
    ST_TEST,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SGN_ADD,
    SGN_SUB,
    SGN_NONE
  } sgn_t;

  typedef enum logic {
    ITER_SQRT,
    ITER_DIV
  } iter_mode_t;

  typedef struct packed {
    logic       start;
    iter_mode_t mode;
  } iter_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

  // matrix column that feeds each plane
  function automatic logic [1:0] plane_col(input logic [2:0] p);
    logic [1:0] c;
    case (p)
      3'd0, 3'd1: c = 2'd0;
      3'd2, 3'd3: c = 2'd1;
      default:    c = 2'd2;
    endcase
    return c;
  endfunction

  // how the column combines with column 3
  function automatic sgn_t plane_sgn(input logic [2:0] p);
    sgn_t s;
    case (p)
      3'd0, 3'd3: s = SGN_ADD;
      3'd4:       s = SGN_NONE;
      default:    s = SGN_SUB;
    endcase
    return s;
  endfunction

endpackage

// File: hdl/fpc_iter.sv
// ---------------------------------------------------------------------------
// fpc_iter
// Shared shift-and-subtract unit: 64-bit integer square root or an unsigned
// DW-bit by 32-bit division, one result bit per cycle.
// ---------------------------------------------------------------------------
module fpc_iter import fpc_pkg::*; #(
  parameter int DW = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  iter_ctl_t   ctl,
  input  logic [63:0] operand,
  input  logic [31:0] divisor,
  output iter_stat_t  stat,
  output logic [63:0] result
);

  localparam logic [63:0] DMASK = {{(64 - DW){1'b0}}, {DW{1'b1}}};

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitm;
  logic [5:0]  cnt;
  iter_mode_t  mode;
  logic        busy;
  logic        done;

  logic [63:0] trial;
  logic [32:0] dsh;
  logic        dge;

  assign trial = res + bitm;
  assign dsh   = {rem[31:0], res[DW-1]};
  assign dge   = dsh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        mode <= ctl.mode;
        if (ctl.mode == ITER_SQRT) begin
          cnt  <= 6'(SQRT_STEPS - 1);
          rem  <= operand;
          res  <= '0;
          bitm <= 64'h4000_0000_0000_0000;
        end else begin
          cnt <= 6'(DW - 1);
          rem <= '0;
          res <= operand & DMASK;
        end
      end else if (busy) begin
        if (mode == ITER_SQRT) begin
          if (rem >= trial) begin
            rem <= rem - trial;
            res <= (res >> 1) + bitm;
          end else begin
            res <= res >> 1;
          end
          bitm <= bitm >> 2;
        end else begin
          rem <= dge ? {31'd0, dsh - {1'b0, divisor}} : {31'd0, dsh};
          res <= {res[62:0], dge};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = (mode == ITER_SQRT) ? res : (res & DMASK);

endmodule

// File: hdl/frustum_plane_cull.sv
// ---------------------------------------------------------------------------
// frustum_plane_cull
// Frustum plane extraction and box / sphere visibility test, Q fixed point.
// ---------------------------------------------------------------------------
// One item is taken at a time and every item gives one result beat. In a box
// or sphere test one 32x32 multiplier handles one plane term per cycle, fed
// from the plane coefficient memory. Plane extraction is slow and meant to run
// rarely; each plane runs through the shared shift-and-subtract unit (32-step
// square root, then one divide per coefficient). Planes beyond the sixth stay
// zero and never cull.
module frustum_plane_cull import fpc_pkg::*; #(
  parameter int PLANE_COUNT = 6,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // element_index[3:0], element_value[35:4], px[67:36], py[99:68],
  // pz[131:100], qx[163:132], qy[195:164], qz[227:196], radius[258:228]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // visible[0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // answered[0]
  output logic                   m_axis_tuser
);

  localparam int NC  = PLANE_COUNT * 4;
  localparam int CAW = $clog2(NC);
  localparam int NE  = (PLANE_COUNT < MAX_EXTRACT) ? PLANE_COUNT : MAX_EXTRACT;
  localparam int DW  = 32 + FRAC_BITS;
  localparam logic signed [31:0] SCALE = 32'sd1 <<< FRAC_BITS;

  // input fields
  op_t                in_op;
  logic [3:0]         in_idx;
  logic signed [31:0] in_val;
  logic [30:0]        in_rad;
  logic               accept;

  assign in_op  = op_t'(s_axis_tuser);
  assign in_idx = s_axis_tdata[3:0];
  assign in_val = s_axis_tdata[35:4];
  assign in_rad = s_axis_tdata[258:228];
  assign accept = s_axis_tvalid && s_axis_tready;

  state_t state;
  state_t state_next;

  op_t                op_q;
  logic signed [31:0] lo_pt [3];
  logic signed [31:0] hi_pt [3];
  logic [30:0]        rad;
  logic               vis;
  logic               ans;

  // extraction
  logic [2:0]         ep;
  logic [2:0]         jc;
  logic               rv;
  logic [1:0]         rj;
  logic signed [31:0] raw [4];
  logic [63:0]        sq;
  logic [31:0]        len;
  logic               launched;

  // test pipeline
  logic [CAW:0]              tc;
  logic                      v1;
  logic [1:0]                k1;
  logic                      v2;
  logic                      lp2;
  logic signed [63:0]        prod;
  logic signed [ACCW-1:0]    acc;
  logic signed [ACCW-1:0]    acc_sum;
  logic signed [ACCW-1:0]    acc_init;

  // matrix memory
  logic signed [31:0] mtx [16];
  logic [15:0]        mvld;
  logic [3:0]         mra;
  logic [3:0]         mrb;
  logic signed [31:0] mrd_a;
  logic signed [31:0] mrd_b;
  logic               mwe;

  // plane coefficient memory
  logic signed [31:0] cmem [NC];
  logic [NC-1:0]      cvld;
  logic [CAW-1:0]     craddr;
  logic signed [31:0] crd;
  logic               cwe;
  logic [CAW-1:0]     cwaddr;
  logic signed [31:0] cwdata;

  // shared units
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;
  iter_ctl_t          itr_ctl;
  iter_stat_t         itr_stat;
  logic [63:0]        itr_opnd;
  logic [63:0]        itr_res;

  logic signed [31:0] raw_val;
  logic signed [32:0] raw_s33;
  logic signed [31:0] raw_j;
  logic [31:0]        mag;
  logic [32:0]        qsat;
  logic signed [31:0] qval;
  logic signed [31:0] pt_lo;
  logic signed [31:0] pt_hi;

  logic m_vis;
  logic m_ans;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {{(OUT_TDATA_W - 1){1'b0}}, m_vis};
  assign m_axis_tuser  = m_ans;

  // ---- raw plane value from two matrix reads, saturated to 32 bits
  always_comb begin
    raw_s33 = '0;
    case (plane_sgn(ep))
      SGN_ADD: raw_s33 = {mrd_b[31], mrd_b} + {mrd_a[31], mrd_a};
      SGN_SUB: raw_s33 = {mrd_b[31], mrd_b} - {mrd_a[31], mrd_a};
      default: raw_s33 = {mrd_a[31], mrd_a};
    endcase
    if (raw_s33[32] != raw_s33[31]) begin
      raw_val = raw_s33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      raw_val = raw_s33[31:0];
    end
  end

  assign mra = {jc[1:0], plane_col(ep)};
  assign mrb = {jc[1:0], 2'd3};
  assign mwe = accept && (in_op == OP_WRITE);

  // ---- normalized coefficient from the divider result
  assign raw_j = raw[jc[1:0]];
  assign mag   = raw_j[31] ? (~raw_j + 32'd1) : raw_j;
  assign qsat  = (itr_res > 64'h8000_0000) ? 33'h0_8000_0000 : itr_res[32:0];
  always_comb begin
    if (raw_j[31]) begin
      qval = -qsat[31:0];
    end else if (qsat[31]) begin
      qval = 32'sh7FFF_FFFF;
    end else begin
      qval = qsat[31:0];
    end
  end

  // ---- shared multiplier operands
  always_comb begin
    case (k1)
      2'd0:    begin pt_lo = lo_pt[0]; pt_hi = hi_pt[0]; end
      2'd1:    begin pt_lo = lo_pt[1]; pt_hi = hi_pt[1]; end
      default: begin pt_lo = lo_pt[2]; pt_hi = hi_pt[2]; end
    endcase
    if (state == ST_EX_SQ) begin
      mul_a = raw_j;
      mul_b = raw_j;
    end else if (k1 == 2'd3) begin
      mul_a = crd;
      mul_b = SCALE;
    end else begin
      mul_a = (op_q == OP_BOX && !crd[31]) ? pt_hi : pt_lo;
      mul_b = crd;
    end
  end

  assign mul_p    = mul_a * mul_b;
  assign acc_sum  = acc + ACCW'(prod);
  assign acc_init = (op_q == OP_SPHERE) ?
                    ({{(ACCW - 31){1'b0}}, rad} << FRAC_BITS) : '0;
  assign craddr   = tc[CAW-1:0];

  // ---- state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- next state and unit control
  always_comb begin
    state_next = state;
    itr_ctl    = '0;
    itr_opnd   = '0;
    cwe        = 1'b0;
    cwaddr     = CAW'({ep, jc[1:0]});
    cwdata     = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_WRITE:   state_next = ST_DONE;
            OP_EXTRACT: state_next = ST_EX_RD;
            default:    state_next = ST_TEST;
          endcase
        end
      end
      ST_EX_RD: begin
        if (jc == 3'd4 && !rv) state_next = ST_EX_SQ;
      end
      ST_EX_SQ: begin
        if (jc == 3'd3 && !v2) begin
          if (sq == 64'd0) begin
            state_next = ST_EX_ZERO;
          end else begin
            itr_ctl.start = 1'b1;
            itr_ctl.mode  = ITER_SQRT;
            itr_opnd      = sq;
            state_next    = ST_EX_ROOT;
          end
        end
      end
      ST_EX_ROOT: begin
        if (itr_stat.done) state_next = ST_EX_DIV;
      end
      ST_EX_DIV: begin
        if (!launched) begin
          itr_ctl.start = 1'b1;
          itr_ctl.mode  = ITER_DIV;
          itr_opnd      = {32'd0, mag} << FRAC_BITS;
        end else if (itr_stat.done) begin
          cwe    = 1'b1;
          cwdata = qval;
          if (jc == 3'd3) state_next = (ep == 3'(NE - 1)) ? ST_DONE : ST_EX_RD;
        end
      end
      ST_EX_ZERO: begin
        cwe = 1'b1;
        if (jc == 3'd3) state_next = (ep == 3'(NE - 1)) ? ST_DONE : ST_EX_RD;
      end
      ST_TEST: begin
        if (tc == (CAW+1)'(NC) && !v1 && !v2) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---- datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      rv            <= 1'b0;
      launched      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      rv <= 1'b0;
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_q     <= in_op;
            lo_pt[0] <= s_axis_tdata[67:36];
            lo_pt[1] <= s_axis_tdata[99:68];
            lo_pt[2] <= s_axis_tdata[131:100];
            hi_pt[0] <= s_axis_tdata[163:132];
            hi_pt[1] <= s_axis_tdata[195:164];
            hi_pt[2] <= s_axis_tdata[227:196];
            rad      <= in_rad;
            vis      <= in_op[1];
            ans      <= in_op[1];
            ep       <= '0;
            jc       <= '0;
            tc       <= '0;
            acc      <= (in_op == OP_SPHERE) ?
                        ({{(ACCW - 31){1'b0}}, in_rad} << FRAC_BITS) : '0;
          end
        end
        ST_EX_RD: begin
          if (jc != 3'd4) begin
            rv <= 1'b1;
            rj <= jc[1:0];
            jc <= jc + 3'd1;
          end
          if (rv) raw[rj] <= raw_val;
          if (jc == 3'd4 && !rv) begin
            jc <= '0;
            sq <= '0;
          end
        end
        ST_EX_SQ: begin
          if (jc != 3'd3) begin
            prod <= mul_p;
            v2   <= 1'b1;
            jc   <= jc + 3'd1;
          end
          if (v2) sq <= sq + prod;
          if (jc == 3'd3 && !v2) begin
            jc       <= '0;
            launched <= 1'b0;
          end
        end
        ST_EX_ROOT: begin
          if (itr_stat.done) len <= itr_res[31:0];
        end
        ST_EX_DIV: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (itr_stat.done) begin
            launched <= 1'b0;
            if (jc == 3'd3) begin
              ep <= ep + 3'd1;
              jc <= '0;
            end else begin
              jc <= jc + 3'd1;
            end
          end
        end
        ST_EX_ZERO: begin
          if (jc == 3'd3) begin
            ep <= ep + 3'd1;
            jc <= '0;
          end else begin
            jc <= jc + 3'd1;
          end
        end
        ST_TEST: begin
          if (tc != (CAW+1)'(NC)) begin
            v1 <= 1'b1;
            k1 <= tc[1:0];
            tc <= tc + (CAW+1)'(1);
          end
          if (v1) begin
            prod <= mul_p;
            v2   <= 1'b1;
            lp2  <= (k1 == 2'd3);
          end
          // close each plane: exact sign of the full sum decides the cull
          if (v2) begin
            if (lp2) begin
              if (acc_sum < 0) vis <= 1'b0;
              acc <= acc_init;
            end else begin
              acc <= acc_sum;
            end
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_vis         <= vis;
            m_ans         <= ans;
          end
        end
        default: ;
      endcase
    end
  end

  // ---- matrix memory, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      mvld <= '0;
    end else if (mwe) begin
      mvld[in_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mwe) mtx[in_idx] <= in_val;
    mrd_a <= mvld[mra] ? mtx[mra] : 32'sd0;
    mrd_b <= mvld[mrb] ? mtx[mrb] : 32'sd0;
  end

  // ---- plane coefficient memory, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      cvld <= '0;
    end else if (cwe) begin
      cvld[cwaddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cwe) cmem[cwaddr] <= cwdata;
    crd <= cvld[craddr] ? cmem[craddr] : 32'sd0;
  end

  fpc_iter #(
    .DW (DW)
  ) u_iter (
    .clk     (clk),
    .rst     (rst),
    .ctl     (itr_ctl),
    .operand (itr_opnd),
    .divisor (len),
    .stat    (itr_stat),
    .result  (itr_res)
  );

`include "frustum_plane_cull_assert.svh"

  `FPC_ASSERT_IMPLIES(a_ready_unit_idle, s_axis_tready, !itr_stat.busy)
  `FPC_ASSERT_NEXT(a_write_to_done, accept && in_op == OP_WRITE, state == ST_DONE)
  `FPC_ASSERT_IMPLIES(a_no_answer_invisible, m_axis_tvalid && !m_axis_tuser, !m_axis_tdata[0])
  `FPC_ASSERT_IMPLIES(a_done_in_extract, itr_stat.done, state == ST_EX_ROOT || state == ST_EX_DIV)

endmodule

// File: tb/frustum_plane_cull_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// frustum_plane_cull_tb
// Self-checking bench: matrix writes, plane extraction and box / sphere
// culling are driven over the stream ports and scored against a local model.
// ---------------------------------------------------------------------------
module frustum_plane_cull_tb import fpc_pkg::*;;

  localparam int PLANES = 6;
  localparam int FRAC   = 16;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = OP_WRITE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  frustum_plane_cull #(.PLANE_COUNT(PLANES), .FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct {
    op_t              op;
    logic [3:0]       idx;
    logic signed [31:0] val;
    logic signed [31:0] p [3];
    logic signed [31:0] q [3];
    logic [30:0]      radius;
  } cull_req_t;

  typedef struct {
    logic visible;
    logic answered;
  } cull_res_t;

  // model state
  logic signed [31:0] mat [16];
  logic signed [31:0] plane [PLANES*4];

  cull_res_t verdicts [$];
  int  errors = 0;
  int  send_idle = 7;
  int  recv_idle = 84;
  bit  hold_off = 1'b0;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void extract_planes();
    logic signed [63:0] raw [4];
    logic signed [63:0] e, w;
    logic [63:0] sq, len, mag, quo;
    int col;
    for (int p = 0; p < PLANES && p < 6; p++) begin
      col = (p < 2) ? 0 : (p < 4) ? 1 : 2;
      for (int j = 0; j < 4; j++) begin
        e = mat[j*4 + col];
        w = mat[j*4 + 3];
        if (p == 0 || p == 3) raw[j] = sat32(w + e);
        else if (p == 4) raw[j] = e;
        else raw[j] = sat32(w - e);
      end
      sq = 0;
      for (int j = 0; j < 3; j++) sq += 64'(raw[j] * raw[j]);
      if (sq == 0) begin
        for (int j = 0; j < 4; j++) plane[p*4 + j] = 0;
      end else begin
        len = root64(sq);
        for (int j = 0; j < 4; j++) begin
          mag = raw[j] < 0 ? 64'(-raw[j]) : 64'(raw[j]);
          quo = (mag << FRAC) / len;
          if (quo > 64'h8000_0000) quo = 64'h8000_0000;
          plane[p*4 + j] = 32'(sat32(raw[j] < 0 ? -$signed(quo) : $signed(quo)));
        end
      end
    end
  endfunction

  function automatic cull_res_t predict_cull(input cull_req_t r);
    cull_res_t res;
    logic signed [127:0] sum;
    logic signed [63:0] c;
    res.visible = 1'b0;
    res.answered = 1'b0;
    if (r.op == OP_WRITE) begin
      mat[r.idx] = r.val;
      return res;
    end
    if (r.op == OP_EXTRACT) begin
      extract_planes();
      return res;
    end
    res.visible = 1'b1;
    res.answered = 1'b1;
    for (int p = 0; p < PLANES; p++) begin
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        c = plane[p*4 + k];
        if (r.op == OP_BOX && c >= 0) sum += 128'(c) * 128'(r.q[k]);
        else sum += 128'(c) * 128'(r.p[k]);
      end
      sum += 128'(plane[p*4 + 3]) <<< FRAC;
      if (r.op == OP_SPHERE) sum += 128'($signed({1'b0, r.radius})) <<< FRAC;
      if (sum < 0) res.visible = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_req(input cull_req_t r);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[3:0]     = r.idx;
    d[35:4]    = r.val;
    d[67:36]   = r.p[0];
    d[99:68]   = r.p[1];
    d[131:100] = r.p[2];
    d[163:132] = r.q[0];
    d[195:164] = r.q[1];
    d[227:196] = r.q[2];
    d[258:228] = r.radius;
    return d;
  endfunction

  // offer one beat; valid stays high across back-to-back beats
  task automatic send_req(input cull_req_t r);
    cull_res_t e;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_req(r);
    s_axis_tuser  <= r.op;
    do @(posedge clk); while (!s_axis_tready);
    e = predict_cull(r);
    verdicts.push_back(e);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(131072*64)) - 32'sd4194304;
      2: return $signed($urandom_range(2048)) - 32'sd1024;
      default: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  function automatic cull_req_t rnd_req(input op_t op);
    cull_req_t r;
    r.op = op;
    r.idx = $urandom_range(15);
    r.val = rnd_coord();
    for (int k = 0; k < 3; k++) begin
      r.p[k] = rnd_coord();
      r.q[k] = ($urandom_range(3) == 0) ? rnd_coord() : r.p[k] + $urandom_range(1 << 20);
    end
    r.radius = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(1 << 21));
    return r;
  endfunction

  // receiver
  always @(posedge clk) begin
    cull_res_t e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts.size() == 0) begin
          $error("result beat with no expectation");
          errors++;
        end else begin
          e = verdicts.pop_front();
          if (m_axis_tdata[0] !== e.visible) begin
            $error("visible: expected %0b, actual %0b", e.visible, m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tuser !== e.answered) begin
            $error("answered: expected %0b, actual %0b", e.answered, m_axis_tuser);
            errors++;
          end
        end
      end
      m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  // long receiver hold-off, counted on its own
  initial begin
    wait (!rst);
    repeat (20000) @(posedge clk);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #60_000_000;
    $display("FAILURE");
    $finish;
  end

  typedef struct {
    op_t op;
    int  idx;
    int  val;
    bit  has_exp;
    bit  exp_vis;
  } row_t;

  row_t rows [$];

  initial begin
    cull_req_t r;
    cull_res_t e;
    logic signed [31:0] diag [4];
    for (int i = 0; i < 16; i++) mat[i] = 0;
    for (int i = 0; i < PLANES*4; i++) plane[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero planes never cull, extremes, identity, saturation
    rows = '{
      '{OP_BOX, 0, 0, 1, 1}, '{OP_SPHERE, 0, 0, 1, 1}, '{OP_EXTRACT, 0, 0, 1, 0},
      '{OP_BOX, 0, 0, 1, 1},
      '{OP_WRITE, 0, 32'h10000, 1, 0}, '{OP_WRITE, 5, 32'h10000, 1, 0},
      '{OP_WRITE, 10, 32'h10000, 1, 0}, '{OP_WRITE, 15, 32'h10000, 1, 0},
      '{OP_EXTRACT, 0, 0, 1, 0}, '{OP_BOX, 0, 0, 0, 0}, '{OP_SPHERE, 0, 0, 0, 0},
      '{OP_WRITE, 3, 32'h7fffffff, 1, 0}, '{OP_WRITE, 0, 32'h7fffffff, 1, 0},
      '{OP_WRITE, 12, 32'h80000000, 1, 0}, '{OP_EXTRACT, 0, 0, 1, 0},
      '{OP_SPHERE, 0, 0, 0, 0}, '{OP_BOX, 0, 0, 0, 0}
    };
    foreach (rows[i]) begin
      r = rnd_req(rows[i].op);
      r.idx = 4'(rows[i].idx);
      r.val = rows[i].val;
      if (i < 4) begin
        for (int k = 0; k < 3; k++) begin
          r.p[k] = 32'sh8000_0000;
          r.q[k] = 32'sh7fff_ffff;
        end
        r.radius = (i == 1) ? 31'h7fff_ffff : 31'd0;
      end
      send_req(r);
      if (rows[i].has_exp) begin
        e = verdicts[$];
        if (e.visible !== rows[i].exp_vis || e.answered !== (rows[i].op >= OP_BOX)) begin
          $error("directed row %0d: model disagrees with table", i);
          errors++;
        end
      end
    end
    drain();

    // random: build a matrix, extract, then many tests
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 7 : ph == 1 ? 84 : 0;
      recv_idle = ph == 0 ? 84 : ph == 1 ? 7 : 0;
      for (int frame = 0; frame < 10; frame++) begin
        for (int i = 0; i < 16; i++) begin
          r = rnd_req(OP_WRITE);
          r.idx = i;
          if ($urandom_range(4) == 0) r.val = 0;
          else if ($urandom_range(1)) r.val = $signed($urandom_range(1 << 18)) - 32'sd131072;
          send_req(r);
        end
        send_req(rnd_req(OP_EXTRACT));
        for (int t = 0; t < 28; t++) begin
          if ($urandom_range(19) == 0) send_req(rnd_req(OP_WRITE));
          else send_req(rnd_req($urandom_range(1) ? OP_BOX : OP_SPHERE));
        end
      end
      drain();
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/fpc_pkg.sv
hdl/fpc_iter.sv
hdl/frustum_plane_cull.sv
tb/frustum_plane_cull_tb.sv
